// ----- hdl/button_press_timing_fsm_macros.svh -----
// Assertion macros shared by the button timing checker.
`ifndef BUTTON_PRESS_TIMING_FSM_MACROS_SVH
`define BUTTON_PRESS_TIMING_FSM_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BPTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BPTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bptf_pkg.sv -----
// Package with the types, register indexes and transition table of the button timer.
package bptf_pkg;

  // Width of the tick counter and of the loaded durations.
  localparam int TICK_W = 32;
  localparam int DUR_W  = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACTIVE_LEVEL  = 2'd0;
  localparam logic [1:0] REG_PRESS_TICKS   = 2'd1;
  localparam logic [1:0] REG_RELEASE_TICKS = 2'd2;

  // Reset value of both timing registers.
  localparam logic [DUR_W-1:0] DUR_RESET = 16'd50;

  // Button states, one-hot. The state number is the bit position.
  typedef enum logic [7:0] {
    ST_IDLE           = 8'b0000_0001,
    ST_PRESS_TIMING   = 8'b0000_0010,
    ST_SHORT_PRESS    = 8'b0000_0100,
    ST_LONG_PRESS     = 8'b0000_1000,
    ST_LONG_HOLD      = 8'b0001_0000,
    ST_RELEASE_TIMING = 8'b0010_0000,
    ST_RELEASE_WAIT   = 8'b0100_0000,
    ST_DOUBLE_PRESS   = 8'b1000_0000
  } st_t;

  // Configuration registers as seen by the core.
  typedef struct packed {
    logic             active_level;
    logic [DUR_W-1:0] press_ticks;
    logic [DUR_W-1:0] release_ticks;
  } cfg_t;

  // Transition table: next state from current state, pressed and timeout bits.
  function automatic st_t bptf_next(st_t cur, logic pressed, logic expired);
    st_t nxt;
    nxt = ST_IDLE;
    case (cur)
      ST_IDLE, ST_DOUBLE_PRESS: begin
        nxt = pressed ? ST_PRESS_TIMING : ST_IDLE;
      end
      ST_PRESS_TIMING: begin
        if (!pressed) nxt = ST_RELEASE_TIMING;
        else if (expired) nxt = ST_PRESS_TIMING;
        else nxt = ST_SHORT_PRESS;
      end
      ST_SHORT_PRESS: begin
        if (pressed) nxt = expired ? ST_LONG_PRESS : ST_SHORT_PRESS;
        else nxt = expired ? ST_RELEASE_TIMING : ST_DOUBLE_PRESS;
      end
      ST_LONG_PRESS, ST_LONG_HOLD: begin
        nxt = pressed ? ST_LONG_HOLD : ST_RELEASE_TIMING;
      end
      ST_RELEASE_TIMING: begin
        if (pressed) nxt = ST_PRESS_TIMING;
        else nxt = expired ? ST_IDLE : ST_RELEASE_WAIT;
      end
      ST_RELEASE_WAIT: begin
        if (pressed) nxt = ST_PRESS_TIMING;
        else nxt = expired ? ST_DOUBLE_PRESS : ST_RELEASE_WAIT;
      end
      default: nxt = ST_IDLE;
    endcase
    return nxt;
  endfunction

  // State number of a one-hot state.
  function automatic logic [2:0] bptf_code(st_t st);
    logic [2:0] code;
    code = 3'd0;
    case (st)
      ST_IDLE:           code = 3'd0;
      ST_PRESS_TIMING:   code = 3'd1;
      ST_SHORT_PRESS:    code = 3'd2;
      ST_LONG_PRESS:     code = 3'd3;
      ST_LONG_HOLD:      code = 3'd4;
      ST_RELEASE_TIMING: code = 3'd5;
      ST_RELEASE_WAIT:   code = 3'd6;
      ST_DOUBLE_PRESS:   code = 3'd7;
      default:           code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/bptf_core.sv -----
// State machine and timer of the button timer: one poll evaluated per step.
module bptf_core import bptf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              pin_level,
  input  logic [TICK_W-1:0] now_tick,
  input  cfg_t              cfg,
  output logic [2:0]        button_state,
  output logic              timer_expired
);

  st_t               state_r, state_nxt, table_next;
  logic [TICK_W-1:0] start_r, start_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              pressed;
  logic [TICK_W-1:0] elapsed;
  logic              expired;

  // Pressed bit, elapsed ticks (wrapping) and the timeout compare.
  always_comb begin
    pressed = (pin_level == cfg.active_level);
    elapsed = now_tick - start_r;
    expired = (elapsed >= {{(TICK_W-DUR_W){1'b0}}, dur_r});
    table_next = bptf_next(state_r, pressed, expired);
  end

  // Timer clears on timeout and restarts on entry to either timing state.
  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    dur_nxt   = dur_r;
    if (step) begin
      state_nxt = table_next;
      if (expired) begin
        start_nxt = '0;
        dur_nxt   = '0;
      end
      if (table_next == ST_PRESS_TIMING) begin
        start_nxt = now_tick;
        dur_nxt   = cfg.press_ticks;
      end else if (table_next == ST_RELEASE_TIMING) begin
        start_nxt = now_tick;
        dur_nxt   = cfg.release_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= '0;
      dur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      dur_r   <= dur_nxt;
    end
  end

  assign button_state  = bptf_code(table_next);
  assign timer_expired = expired;

endmodule

// ----- hdl/button_press_timing_fsm.sv -----
// Top level of the button press timer: poll input stage, core and result register.
//
//   channel | ports                                   | direction
//   in      | in_valid in_ready in_pin_level in_now_tick    | poll beats in
//   out     | out_valid out_ready out_button_state out_timer_expired | result beats out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data  | register writes in
//
// One poll per cycle is sustained while results are taken; the result is registered.
// The poll register feeds the state machine, which updates as the poll moves into
// the result register; that move is the only step that touches the timer state.
// A stalled result holds the poll register; input stalls only while both are full.
// Reset is synchronous; cfg_ready is always high and writes take effect at once.
module button_press_timing_fsm import bptf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_pin_level,
  input  logic [TICK_W-1:0] in_now_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_button_state,
  output logic              out_timer_expired,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [DUR_W-1:0]  cfg_data
);

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic              s1_pin_r;
  logic [TICK_W-1:0] s1_tick_r;
  logic              out_valid_r;
  logic [2:0]        out_state_r;
  logic              out_exp_r;
  logic              advance;
  logic              in_take;
  logic [2:0]        core_state;
  logic              core_exp;

  // Handshake: the poll moves on when the result register is free or drains.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level  <= 1'b0;
      cfg_r.press_ticks   <= DUR_RESET;
      cfg_r.release_ticks <= DUR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL:  cfg_r.active_level  <= cfg_data[0];
        REG_PRESS_TICKS:   cfg_r.press_ticks   <= cfg_data;
        REG_RELEASE_TICKS: cfg_r.release_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Poll register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pin_r  <= in_pin_level;
      s1_tick_r <= in_now_tick;
    end
  end

  bptf_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .pin_level     (s1_pin_r),
    .now_tick      (s1_tick_r),
    .cfg           (cfg_r),
    .button_state  (core_state),
    .timer_expired (core_exp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state_r <= core_state;
      out_exp_r   <= core_exp;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_button_state  = out_state_r;
  assign out_timer_expired = out_exp_r;

endmodule

// ----- hdl/bptf_checker.sv -----
// Port-level checker for the button press timer, bound to the top level.
`include "button_press_timing_fsm_macros.svh"

module bptf_checker import bptf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_button_state,
  input logic       out_timer_expired
);

  // State numbers watched on the result channel.
  localparam logic [2:0] CODE_SHORT_PRESS  = 3'd2;
  localparam logic [2:0] CODE_LONG_PRESS   = 3'd3;
  localparam logic [2:0] CODE_RELEASE_WAIT = 3'd6;

  logic       out_stall;
  logic [3:0] out_payload;
  logic       wait_state;
  logic       long_state;

  // Port views shared by the properties below.
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_button_state, out_timer_expired};
  assign wait_state  = (out_button_state == CODE_SHORT_PRESS) ||
                       (out_button_state == CODE_RELEASE_WAIT);
  assign long_state  = (out_button_state == CODE_LONG_PRESS);

  // A stalled result beat holds its payload.
  `BPTF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "stalled beat changed")

  // The input side only stalls while a result beat is stalled.
  `BPTF_ASSERT_NOW(a_in_stall, !in_ready, out_stall, "input stalled without backpressure")

  // Short press and release wait are only entered before the timer runs out.
  `BPTF_ASSERT_NOW(a_no_exp, out_valid && wait_state, !out_timer_expired, "timeout on a wait state")

  // Long press is only entered on a timeout.
  `BPTF_ASSERT_NOW(a_long_exp, out_valid && long_state, out_timer_expired, "long press without timeout")

endmodule

bind button_press_timing_fsm bptf_checker u_bptf_checker (.*);
